/* hdl/edt_pkg.sv */
// ============================================================================
// edt_pkg
// Shared types and constants for the Euclidean distance (tenths) core.
// ============================================================================
package edt_pkg;

  // Input element value width
  localparam int unsigned VALUE_W = 10;
  // Width of one squared difference
  localparam int unsigned SQ_W = 2 * VALUE_W;
  // Result width and saturation value
  localparam int unsigned DIST_W = 17;
  localparam logic [DIST_W-1:0] DIST_MAX = 17'd131071;

  // Stream data widths (payload padded to whole bytes)
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 24;

  // Result queue between accumulator and root unit
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  // Element action codes carried on tuser
  typedef enum logic {
    ACT_REF  = 1'b0,
    ACT_CAND = 1'b1
  } action_e;

endpackage

/* hdl/euclidean_distance_tenths_core.sv */
// ============================================================================
// euclidean_distance_tenths_core
// Streams vector elements, keeps a reference vector and returns the Euclidean
// distance of each candidate vector to it, in tenths, rounded to nearest.
// ============================================================================
// The core takes one element per cycle while tready is high: tuser selects
// reference load or candidate, tlast ends the vector. A three-stage
// accumulator (memory read, square, add) feeds finished sums into a four-entry
// queue. A shared square root unit then works on one result at a time (load,
// 17 two-bit steps at the default MAX_DIM of 64, round, hand-off) and only
// pops the next sum once the last result is taken, so tready drops when the
// queue plus results still in the accumulator fill it. Elements beyond
// MAX_DIM are dropped and flag the result through m_axis_tuser.
module euclidean_distance_tenths_core #(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [edt_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [9:0] element_value
  input  logic [0:0]                         s_axis_tuser,  // [0] action
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [edt_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // [16:0] distance_tenths
  output logic [0:0]                         m_axis_tuser   // [0] too_long
);

  localparam int unsigned SUM_W = edt_pkg::SQ_W + $clog2(MAX_DIM);
  localparam int unsigned DW    = edt_pkg::DIST_W;

  logic                            push;
  logic [SUM_W-1:0]                push_sum;
  logic                            push_long;
  logic [edt_pkg::QUEUE_CNT_W-1:0] free;
  logic                            q_valid;
  logic [SUM_W:0]                  q_data;
  logic                            q_pop;
  logic [DW-1:0]                   distance;
  logic                            too_long;

  edt_front #(
    .MAX_DIM (MAX_DIM),
    .SUM_W   (SUM_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .value_i       (s_axis_tdata[edt_pkg::VALUE_W-1:0]),
    .action_i      (s_axis_tuser[0]),
    .last_i        (s_axis_tlast),
    .free_i        (free),
    .push_o        (push),
    .push_sum_o    (push_sum),
    .push_long_o   (push_long)
  );

  edt_fifo #(
    .DATA_W (SUM_W + 1)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_long, push_sum}),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .free_o      (free)
  );

  edt_back #(
    .SUM_W (SUM_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_sum_i       (q_data[SUM_W-1:0]),
    .q_long_i      (q_data[SUM_W]),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .dist_o        (distance),
    .too_long_o    (too_long)
  );

  // Pad result to whole bytes
  assign m_axis_tdata = {(edt_pkg::M_TDATA_W - DW)'(0), distance};
  assign m_axis_tuser = too_long;

endmodule

/* hdl/edt_front.sv */
// ============================================================================
// edt_front
// Element front end: stores reference elements, squares candidate differences
// and accumulates them, then hands each finished candidate sum to the queue.
// ============================================================================
module edt_front #(
  parameter int unsigned MAX_DIM = 64,
  parameter int unsigned SUM_W   = 26
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [edt_pkg::VALUE_W-1:0]         value_i,
  input  logic                                action_i,
  input  logic                                last_i,
  input  logic [edt_pkg::QUEUE_CNT_W-1:0]     free_i,
  output logic                                push_o,
  output logic [SUM_W-1:0]                    push_sum_o,
  output logic                                push_long_o
);

  localparam int unsigned POS_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned VW     = edt_pkg::VALUE_W;
  localparam int unsigned SW     = edt_pkg::SQ_W;

  // Element position and overflow tracking
  logic [POS_W-1:0] pos_q, pos_d;
  logic             ovf_q, ovf_d;

  // Reference vector storage
  logic [VW-1:0] ref_mem [MAX_DIM];

  // Stage 1: reference read
  logic          s1_valid_q;
  logic          s1_add_q;
  logic          s1_res_q;
  logic          s1_last_q;
  logic          s1_long_q;
  logic [VW-1:0] s1_val_q;
  logic [VW-1:0] s1_ref_q;

  // Stage 2: squared difference
  logic          s2_valid_q;
  logic          s2_add_q;
  logic          s2_res_q;
  logic          s2_last_q;
  logic          s2_long_q;
  logic [SW-1:0] s2_sq_q;

  logic [SUM_W-1:0] sum_q, sum_d;

  logic              accept;
  logic              in_range;
  logic              is_cand;
  logic [ADDR_W-1:0] addr;
  logic [VW-1:0]     diff;
  logic [SW-1:0]     sq;
  logic [1:0]        pend;
  logic [SUM_W-1:0]  sum_next;

  // Reserve a queue slot for every result still in the pipe
  assign pend          = {1'b0, s1_valid_q & s1_res_q} + {1'b0, s2_valid_q & s2_res_q};
  assign s_axis_tready = edt_pkg::QUEUE_CNT_W'(pend) < free_i;
  assign accept        = s_axis_tvalid & s_axis_tready;

  assign in_range = pos_q != POS_W'(MAX_DIM);
  assign is_cand  = action_i == edt_pkg::ACT_CAND;
  assign addr     = pos_q[ADDR_W-1:0];

  // Advance position, saturate at the end, restart on last
  always_comb begin
    pos_d = pos_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (in_range) begin
        pos_d = pos_q + POS_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
      if (last_i) begin
        pos_d = '0;
        ovf_d = 1'b0;
      end
    end
  end

  // Square the difference
  always_comb begin
    diff = (s1_val_q >= s1_ref_q) ? (s1_val_q - s1_ref_q) : (s1_ref_q - s1_val_q);
    sq   = SW'(diff) * SW'(diff);
  end

  // Accumulate; clear at the end of each vector
  always_comb begin
    sum_next = sum_q + (s2_add_q ? SUM_W'(s2_sq_q) : '0);
    sum_d    = sum_q;
    if (s2_valid_q) begin
      sum_d = s2_last_q ? '0 : sum_next;
    end
  end

  assign push_o      = s2_valid_q & s2_res_q;
  assign push_sum_o  = sum_next;
  assign push_long_o = s2_long_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      ovf_q      <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      sum_q      <= '0;
    end else begin
      pos_q      <= pos_d;
      ovf_q      <= ovf_d;
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      sum_q      <= sum_d;
    end
  end

  // Memory and stage payload
  always_ff @(posedge clk_i) begin
    if (accept && in_range) begin
      if (is_cand) begin
        s1_ref_q <= ref_mem[addr];
      end else begin
        ref_mem[addr] <= value_i;
      end
    end
    if (accept) begin
      s1_add_q  <= is_cand & in_range;
      s1_res_q  <= is_cand & last_i;
      s1_last_q <= last_i;
      s1_long_q <= ovf_q | ~in_range;
      s1_val_q  <= value_i;
    end
    if (s1_valid_q) begin
      s2_add_q  <= s1_add_q;
      s2_res_q  <= s1_res_q;
      s2_last_q <= s1_last_q;
      s2_long_q <= s1_long_q;
      s2_sq_q   <= sq;
    end
  end

endmodule

/* hdl/edt_fifo.sv */
// ============================================================================
// edt_fifo
// Small result queue between the accumulator and the square root unit.
// ============================================================================
module edt_fifo #(
  parameter int unsigned DATA_W = 27
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic [DATA_W-1:0]                   push_data_i,
  input  logic                                pop_i,
  output logic                                valid_o,
  output logic [DATA_W-1:0]                   data_o,
  output logic [edt_pkg::QUEUE_CNT_W-1:0]     free_o
);

  localparam int unsigned PW = edt_pkg::QUEUE_PTR_W;
  localparam int unsigned CW = edt_pkg::QUEUE_CNT_W;

  logic [DATA_W-1:0] mem_q [edt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     count_q;
  logic              do_pop;

  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign free_o  = CW'(edt_pkg::QUEUE_DEPTH) - count_q;
  assign do_pop  = pop_i & valid_o;

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      count_q <= count_q + CW'(push_i) - CW'(do_pop);
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/edt_back.sv */
// ============================================================================
// edt_back
// Square root unit: takes a queued sum, computes round(sqrt(100 * sum)) two
// bits per cycle and holds the result in the output register.
// ============================================================================
module edt_back #(
  parameter int unsigned SUM_W = 26
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  logic [SUM_W-1:0]                  q_sum_i,
  input  logic                              q_long_i,
  output logic                              q_pop_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [edt_pkg::DIST_W-1:0]        dist_o,
  output logic                              too_long_o
);

  localparam int unsigned SCL_W = SUM_W + 7;
  localparam int unsigned LP_W  = SCL_W + (SCL_W % 2);
  localparam int unsigned RT_W  = LP_W / 2 + 1;
  localparam int unsigned DW    = edt_pkg::DIST_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ROUND,
    ST_OUT
  } state_e;

  state_e            state_q;
  logic [LP_W-1:0]   rem_q, root_q, bit_q;
  logic              long_q;
  logic              out_valid_q;
  logic [DW-1:0]     dist_q;
  logic              too_long_q;

  logic [LP_W-1:0]   scaled;
  logic [LP_W:0]     trial;
  logic              ge;
  logic [RT_W-1:0]   rounded;
  logic [31:0]       rounded32;
  logic [DW-1:0]     dist_sat;

  // Scale by one hundred with shifts
  assign scaled = (LP_W'(q_sum_i) << 6) + (LP_W'(q_sum_i) << 5) + (LP_W'(q_sum_i) << 2);

  // One restoring step
  assign trial = {1'b0, root_q} + {1'b0, bit_q};
  assign ge    = {1'b0, rem_q} >= trial;

  // Round to nearest using the remainder, then saturate
  assign rounded   = root_q[RT_W-1:0] + RT_W'(rem_q > root_q);
  assign rounded32 = 32'(rounded);
  assign dist_sat  = (rounded32 > 32'(edt_pkg::DIST_MAX)) ? edt_pkg::DIST_MAX
                                                            : rounded32[DW-1:0];

  assign q_pop_o       = (state_q == ST_IDLE) & q_valid_i;
  assign m_axis_tvalid = out_valid_q;
  assign dist_o        = dist_q;
  assign too_long_o    = too_long_q;

  // Sequence load, iterate, round and hand off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rem_q       <= '0;
      root_q      <= '0;
      bit_q       <= '0;
      long_q      <= 1'b0;
      out_valid_q <= 1'b0;
      dist_q      <= '0;
      too_long_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            rem_q   <= scaled;
            root_q  <= '0;
            bit_q   <= LP_W'(1) << (LP_W - 2);
            long_q  <= q_long_i;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (ge) begin
            rem_q  <= rem_q - trial[LP_W-1:0];
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          dist_q      <= dist_sat;
          too_long_q  <= long_q;
          out_valid_q <= 1'b1;
          state_q     <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/edt_checker.sv */
// ============================================================================
// edt_checker
// Port-level checks for the Euclidean distance core, bound to the top level.
// ============================================================================
module edt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [edt_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic [0:0]                    s_axis_tuser,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [edt_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]                    m_axis_tuser
);

  // Hold a pending result until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before transaction completed");

  // Keep the padding above the distance clear
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[edt_pkg::M_TDATA_W-1:edt_pkg::DIST_W] == '0)
    else $error("result padding not zero");

  // No result directly out of reset
  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A result never appears in the cycle after the previous one was taken
  a_result_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("back-to-back results from root unit");

endmodule

bind euclidean_distance_tenths_core edt_checker u_edt_checker (.*);

/* sim/euclidean_distance_tenths_core_test.sv */
// ============================================================================
// euclidean_distance_tenths_core_test
// Self-checking bench for the Euclidean distance core. Reference and
// candidate vectors stream in through the element port. A local model tracks
// the stored reference, the position and the exact square sum, and it queues
// the rounded distance for every candidate vector. Each result transaction is
// checked against the oldest queued distance. Pacing runs through several
// phases of sender idling and receiver stalls, and one long receiver hold-off
// backs the core up until it stalls its input.
// ============================================================================
module euclidean_distance_tenths_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_W     = edt_pkg::VALUE_W;
  localparam int unsigned DIST_W      = edt_pkg::DIST_W;
  localparam int unsigned S_TDATA_W   = edt_pkg::S_TDATA_W;
  localparam int unsigned M_TDATA_W   = edt_pkg::M_TDATA_W;

  localparam int unsigned MAX_DIM     = 64;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 330;
  localparam int unsigned TAIL_CYCLES = 60;

  // Pacing applied while an element is on its way through the core
  typedef enum logic [2:0] {
    PACE_FULL,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH,
    PACE_HOLD
  } pace_e;

  typedef struct packed {
    edt_pkg::action_e   action;
    logic [VALUE_W-1:0] value;
    logic               last;
    pace_e              pace;
  } element_t;

  typedef struct packed {
    logic [DIST_W-1:0] tenths;
    logic              too_long;
  } distance_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // [9:0] element_value
  logic [0:0]           s_axis_tuser = '0;  // [0] action
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;       // [16:0] distance_tenths
  logic [0:0]           m_axis_tuser;       // [0] too_long

  element_t  pending_elems[$];
  distance_t distances_due[$];
  int        fail_count = 0;
  pace_e     pace = PACE_FULL;

  // Model state of the core
  logic [VALUE_W-1:0] ref_mem[MAX_DIM];
  int unsigned        acc_pos = 0;
  longint unsigned    acc_sum = 0;
  bit                 acc_over = 1'b0;

  // Stimulus-side view of position and written reference entries
  int unsigned gen_pos = 0;
  bit          gen_written[MAX_DIM];

  euclidean_distance_tenths_core #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Integer square root, one result bit per step from the top
  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Distance times ten, rounded half away from zero, saturated to the port
  function automatic logic [DIST_W-1:0] rounded_tenths(input longint unsigned sum);
    longint unsigned scaled;
    longint unsigned r;
    scaled = sum * 100;
    r = floor_root(scaled);
    if (scaled > r * r + r) r++;
    if (r > 64'(edt_pkg::DIST_MAX)) r = 64'(edt_pkg::DIST_MAX);
    return r[DIST_W-1:0];
  endfunction

  // Advance the model by one accepted element
  task automatic accumulate_element(input element_t e);
    logic [VALUE_W-1:0] stored;
    longint unsigned    diff;
    distance_t          res;
    if (acc_pos < MAX_DIM) begin
      if (e.action == edt_pkg::ACT_CAND) begin
        stored = ref_mem[acc_pos];
        diff = (e.value >= stored) ? e.value - stored : stored - e.value;
        acc_sum += diff * diff;
      end else begin
        ref_mem[acc_pos] = e.value;
      end
      acc_pos++;
    end else begin
      acc_over = 1'b1;
    end
    if (e.last) begin
      if (e.action == edt_pkg::ACT_CAND) begin
        res.tenths = rounded_tenths(acc_sum);
        res.too_long = acc_over;
        distances_due = {distances_due, res};
      end
      acc_pos = 0;
      acc_sum = 0;
      acc_over = 1'b0;
    end
  endtask

  // Queue one element and track which reference entries exist
  task automatic add_elem(input edt_pkg::action_e act, input logic [VALUE_W-1:0] value,
                          input logic last, input pace_e p);
    element_t e;
    e.action = act;
    e.value = value;
    e.last = last;
    e.pace = p;
    pending_elems = {pending_elems, e};
    if (gen_pos < MAX_DIM) begin
      if (act == edt_pkg::ACT_REF) gen_written[gen_pos] = 1'b1;
      gen_pos++;
    end
    if (last) gen_pos = 0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return 10'd999;
    if (r < 22) return VALUE_W'($urandom_range(1000, 1023));
    return VALUE_W'($urandom_range(0, 999));
  endfunction

  // Length of the written reference prefix
  function automatic int unsigned written_len();
    for (int i = 0; i < MAX_DIM; i++)
      if (!gen_written[i]) return i;
    return MAX_DIM;
  endfunction

  task automatic send_vector(input edt_pkg::action_e act, input int unsigned len,
                             input pace_e p);
    for (int unsigned i = 0; i < len; i++)
      add_elem(act, pick_value(), i == len - 1, p);
  endtask

  task automatic send_reference(input pace_e p);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) send_vector(edt_pkg::ACT_REF, $urandom_range(1, 8), p);
    else if (r < 90) send_vector(edt_pkg::ACT_REF, $urandom_range(9, MAX_DIM - 1), p);
    else send_vector(edt_pkg::ACT_REF, $urandom_range(MAX_DIM, MAX_DIM + 6), p);
  endtask

  // Candidate lengths stay inside the written prefix unless it is complete
  task automatic send_candidate(input pace_e p);
    int unsigned hi;
    int unsigned r;
    int unsigned len;
    hi = written_len();
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(1, (hi < 8) ? hi : 8);
    else if (r < 85 || hi < MAX_DIM) len = hi;
    else len = $urandom_range(MAX_DIM + 1, MAX_DIM + 6);
    send_vector(edt_pkg::ACT_CAND, len, p);
  endtask

  // Mixed actions in one vector; never read an unwritten entry
  task automatic send_mixed(input pace_e p);
    int unsigned      len;
    edt_pkg::action_e act;
    len = $urandom_range(1, 10);
    for (int unsigned i = 0; i < len; i++) begin
      act = edt_pkg::action_e'($urandom_range(0, 1));
      if (act == edt_pkg::ACT_CAND && gen_pos < MAX_DIM && !gen_written[gen_pos])
        act = edt_pkg::ACT_REF;
      add_elem(act, pick_value(), i == len - 1, p);
    end
  endtask

  task automatic send_phase(input pace_e p);
    int unsigned start;
    int unsigned r;
    start = pending_elems.size();
    while (pending_elems.size() - start < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 12) send_reference(p);
      else if (r < 87) send_candidate(p);
      else send_mixed(p);
    end
  endtask

  // Driver: present queued elements, idle between them per phase
  always @(posedge clk_i or negedge rst_ni) begin : elem_driver
    element_t cur;
    bit       idle;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      s_axis_tlast <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) accumulate_element(cur);
      if (!s_axis_tvalid || s_axis_tready) begin
        idle = 1'b0;
        if (pending_elems.size() != 0) begin
          case (pending_elems[0].pace)
            PACE_SEND_IDLE: idle = ($urandom_range(0, 99) < 77);
            PACE_BOTH:      idle = ($urandom_range(0, 99) < 16);
            default:        idle = 1'b0;
          endcase
        end
        if (pending_elems.size() != 0 && !idle) begin
          cur = pending_elems.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {{(S_TDATA_W - VALUE_W){1'b0}}, cur.value};
          s_axis_tuser <= cur.action;
          s_axis_tlast <= cur.last;
          pace <= cur.pace;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted once when the hold phase begins
  int unsigned hold_count = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_count <= 0;
      hold_done <= 1'b0;
    end else if (pace == PACE_HOLD && !hold_done) begin
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end
  end

  // Monitor: check each result transaction, then pick the next tready
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    distance_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (distances_due.size() == 0) begin
          $error("unexpected result: distance_tenths %0d too_long %0d",
                 m_axis_tdata[DIST_W-1:0], m_axis_tuser[0]);
          fail_count++;
        end else begin
          want = distances_due.pop_front();
          if (m_axis_tdata[DIST_W-1:0] !== want.tenths) begin
            $error("distance_tenths: expected %0d, got %0d", want.tenths,
                   m_axis_tdata[DIST_W-1:0]);
            fail_count++;
          end
          if (m_axis_tuser[0] !== want.too_long) begin
            $error("too_long: expected %0d, got %0d", want.too_long, m_axis_tuser[0]);
            fail_count++;
          end
        end
      end
      case (pace)
        PACE_RECV_STALL: m_axis_tready <= ($urandom_range(0, 99) >= 77);
        PACE_BOTH:       m_axis_tready <= ($urandom_range(0, 99) >= 16);
        PACE_HOLD:       m_axis_tready <= hold_done;
        default:         m_axis_tready <= 1'b1;
      endcase
    end
  end

  // Stimulus and end of run
  initial begin
    for (int i = 0; i < MAX_DIM; i++) begin
      ref_mem[i] = '0;
      gen_written[i] = 1'b0;
    end

    // Directed: single-element reference and the widest difference
    add_elem(edt_pkg::ACT_REF, 10'd0, 1'b1, PACE_FULL);
    add_elem(edt_pkg::ACT_CAND, 10'd1023, 1'b1, PACE_FULL);
    // Three-element reference, then a distant and an identical candidate
    add_elem(edt_pkg::ACT_REF, 10'd999, 1'b0, PACE_FULL);
    add_elem(edt_pkg::ACT_REF, 10'd0, 1'b0, PACE_FULL);
    add_elem(edt_pkg::ACT_REF, 10'd512, 1'b1, PACE_FULL);
    add_elem(edt_pkg::ACT_CAND, 10'd0, 1'b0, PACE_FULL);
    add_elem(edt_pkg::ACT_CAND, 10'd999, 1'b0, PACE_FULL);
    add_elem(edt_pkg::ACT_CAND, 10'd511, 1'b1, PACE_FULL);
    add_elem(edt_pkg::ACT_CAND, 10'd999, 1'b0, PACE_FULL);
    add_elem(edt_pkg::ACT_CAND, 10'd0, 1'b0, PACE_FULL);
    add_elem(edt_pkg::ACT_CAND, 10'd512, 1'b1, PACE_FULL);
    // Mixed vectors: candidate ending, then reference ending without a result
    add_elem(edt_pkg::ACT_REF, 10'd7, 1'b0, PACE_FULL);
    add_elem(edt_pkg::ACT_CAND, 10'd3, 1'b1, PACE_FULL);
    add_elem(edt_pkg::ACT_CAND, 10'd1000, 1'b0, PACE_FULL);
    add_elem(edt_pkg::ACT_REF, 10'd341, 1'b1, PACE_FULL);
    // Small differences exercise the rounding boundary
    add_elem(edt_pkg::ACT_CAND, 10'd1, 1'b0, PACE_FULL);
    add_elem(edt_pkg::ACT_CAND, 10'd342, 1'b1, PACE_FULL);
    add_elem(edt_pkg::ACT_CAND, 10'd682, 1'b1, PACE_FULL);

    // Full-length reference and an overlong candidate to raise the overflow flag
    send_vector(edt_pkg::ACT_REF, MAX_DIM, PACE_FULL);
    send_vector(edt_pkg::ACT_CAND, MAX_DIM + 4, PACE_FULL);
    send_phase(PACE_FULL);
    send_phase(PACE_SEND_IDLE);
    send_phase(PACE_RECV_STALL);

    // Hold-off: many short candidates back up behind a stalled receiver
    send_vector(edt_pkg::ACT_REF, 2, PACE_HOLD);
    for (int i = 0; i < 40; i++)
      send_vector(edt_pkg::ACT_CAND, $urandom_range(1, 2), PACE_HOLD);

    send_phase(PACE_BOTH);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_elems.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (distances_due.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("** euclidean_distance_tenths_core: PASSED **");
    end else begin
      $display("** euclidean_distance_tenths_core: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("** euclidean_distance_tenths_core: FAILED **");
    $finish;
  end

endmodule
